[hw/rtl/i2p_pkg.sv]
// Shared types, constants and helper functions of the infix-to-postfix converter.
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_ALNUM,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_UNKNOWN
  } cls_t;

  typedef logic [2:0] code_t;
  localparam code_t CODE_OPEN = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_POW  = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNMATCHED = 2'd2;
  localparam status_t ST_UNKNOWN   = 2'd3;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;

  typedef struct packed {
    cls_t       cls;
    code_t      code;
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_last;
    logic       expr_end;
    status_t    status;
  } res_t;

  // write side of the result queue
  typedef struct packed {
    logic push;
    res_t data;
  } oq_wr_t;

  function automatic logic [7:0] code_char(code_t c);
    logic [7:0] ch;
    case (c)
      CODE_ADD: ch = CH_ADD;
      CODE_SUB: ch = CH_SUB;
      CODE_MUL: ch = CH_MUL;
      CODE_DIV: ch = CH_DIV;
      CODE_POW: ch = CH_POW;
      default:  ch = CH_OPEN;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(code_t c);
    logic [1:0] p;
    case (c)
      CODE_ADD, CODE_SUB: p = 2'd1;
      CODE_MUL, CODE_DIV: p = 2'd2;
      CODE_POW:           p = 2'd3;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/i2p_front.sv]
// Front end: classifies incoming characters and queues them for the sequencer.
module i2p_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  logic [7:0]      in_char,
  input  logic            in_expr_last,
  output logic            full,
  input  logic            deq,
  output logic            item_v,
  output i2p_pkg::item_t  item
);

  i2p_pkg::item_t                     item_in;
  i2p_pkg::item_t                     q_r [i2p_pkg::FQ_DEPTH];
  logic [i2p_pkg::FQ_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [i2p_pkg::FQ_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [i2p_pkg::FQ_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                               wr_en, rd_en;

  // classify
  always_comb begin
    item_in.ch   = in_char;
    item_in.last = in_expr_last;
    item_in.code = i2p_pkg::CODE_OPEN;
    if ((in_char >= 8'h61 && in_char <= 8'h7A) || (in_char >= 8'h41 && in_char <= 8'h5A) ||
        (in_char >= 8'h30 && in_char <= 8'h39)) begin
      item_in.cls = i2p_pkg::CLS_ALNUM;
    end else begin
      case (in_char)
        i2p_pkg::CH_OPEN:  item_in.cls = i2p_pkg::CLS_OPEN;
        i2p_pkg::CH_CLOSE: item_in.cls = i2p_pkg::CLS_CLOSE;
        i2p_pkg::CH_ADD: begin
          item_in.cls  = i2p_pkg::CLS_OP;
          item_in.code = i2p_pkg::CODE_ADD;
        end
        i2p_pkg::CH_SUB: begin
          item_in.cls  = i2p_pkg::CLS_OP;
          item_in.code = i2p_pkg::CODE_SUB;
        end
        i2p_pkg::CH_MUL: begin
          item_in.cls  = i2p_pkg::CLS_OP;
          item_in.code = i2p_pkg::CODE_MUL;
        end
        i2p_pkg::CH_DIV: begin
          item_in.cls  = i2p_pkg::CLS_OP;
          item_in.code = i2p_pkg::CODE_DIV;
        end
        i2p_pkg::CH_POW: begin
          item_in.cls  = i2p_pkg::CLS_OP;
          item_in.code = i2p_pkg::CODE_POW;
        end
        default: item_in.cls = i2p_pkg::CLS_UNKNOWN;
      endcase
    end
  end

  assign full   = (cnt_r == i2p_pkg::FQ_CNT_W'(i2p_pkg::FQ_DEPTH));
  assign item_v = (cnt_r != '0);
  assign item   = q_r[rd_ptr_r];
  assign wr_en  = push && !full;
  assign rd_en  = deq && item_v;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == i2p_pkg::FQ_PTR_W'(i2p_pkg::FQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + i2p_pkg::FQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == i2p_pkg::FQ_PTR_W'(i2p_pkg::FQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + i2p_pkg::FQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + i2p_pkg::FQ_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - i2p_pkg::FQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

[hw/rtl/i2p_back.sv]
// Back end: shunting-yard sequencer with the operator stack memory.
module i2p_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_v,
  input  i2p_pkg::item_t  item,
  output logic            deq,
  input  logic            oq_full,
  output i2p_pkg::oq_wr_t oq_wr
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FETCH,
    S_END,
    S_FLUSH,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  state_t                       ret_r, ret_nxt;
  i2p_pkg::item_t               cur_r, cur_nxt;
  logic [i2p_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  i2p_pkg::code_t               top_r, top_nxt;
  i2p_pkg::res_t                hold_r, hold_nxt;
  logic                         hold_v_r, hold_v_nxt;

  i2p_pkg::code_t               stack_mem [i2p_pkg::STACK_DEPTH];
  i2p_pkg::code_t               rd_data_r;
  logic [i2p_pkg::CNT_W-1:0]    cnt_m2;
  logic [i2p_pkg::PTR_W-1:0]    rd_addr;
  logic                         mem_we;

  logic                         go, stk_empty, stk_full, op_pops;
  logic                         emit, finish, do_pop, do_push;
  i2p_pkg::res_t                emit_res;
  i2p_pkg::code_t               push_code;

  function automatic i2p_pkg::res_t mk_res(logic [7:0] ch, logic has, logic fin,
                                           i2p_pkg::status_t st);
    i2p_pkg::res_t r;
    r.ch       = ch;
    r.has_char = has;
    r.run_last = 1'b0;
    r.expr_end = fin;
    r.status   = st;
    return r;
  endfunction

  // new top after a pop sits one below the new count
  assign cnt_m2    = cnt_r - i2p_pkg::CNT_W'(2);
  assign rd_addr   = cnt_m2[i2p_pkg::PTR_W-1:0];
  assign stk_empty = (cnt_r == '0);
  assign stk_full  = (cnt_r == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
  // one held result may be waiting; it moves out only with queue space
  assign go        = !hold_v_r || !oq_full;
  assign op_pops   = !stk_empty &&
                     ((i2p_pkg::code_prec(top_r) > i2p_pkg::code_prec(cur_r.code)) ||
                      ((i2p_pkg::code_prec(top_r) == i2p_pkg::code_prec(cur_r.code)) &&
                       (cur_r.code != i2p_pkg::CODE_POW)));

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    deq        = 1'b0;
    emit       = 1'b0;
    emit_res   = '0;
    finish     = 1'b0;
    do_pop     = 1'b0;
    do_push    = 1'b0;
    push_code  = i2p_pkg::CODE_OPEN;
    mem_we     = 1'b0;
    oq_wr      = '0;

    case (state_r)
      S_IDLE: begin
        if (item_v) begin
          deq       = 1'b1;
          cur_nxt   = item;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (go) begin
          case (cur_r.cls)
            i2p_pkg::CLS_ALNUM: begin
              emit      = 1'b1;
              emit_res  = mk_res(cur_r.ch, 1'b1, 1'b0, i2p_pkg::ST_OK);
              state_nxt = S_END;
            end
            i2p_pkg::CLS_OPEN: begin
              do_push   = 1'b1;
              push_code = i2p_pkg::CODE_OPEN;
              state_nxt = S_END;
            end
            i2p_pkg::CLS_CLOSE: begin
              if (stk_empty) begin
                emit      = 1'b1;
                emit_res  = mk_res(8'h00, 1'b0, 1'b0, i2p_pkg::ST_UNMATCHED);
                state_nxt = S_END;
              end else if (top_r == i2p_pkg::CODE_OPEN) begin
                // drop the matching paren, refetch top
                cnt_nxt   = cnt_r - i2p_pkg::CNT_W'(1);
                ret_nxt   = S_END;
                state_nxt = S_FETCH;
              end else begin
                do_pop  = 1'b1;
                ret_nxt = S_EVAL;
              end
            end
            i2p_pkg::CLS_OP: begin
              if (op_pops) begin
                do_pop  = 1'b1;
                ret_nxt = S_EVAL;
              end else begin
                do_push   = 1'b1;
                push_code = cur_r.code;
                state_nxt = S_END;
              end
            end
            default: begin
              emit      = 1'b1;
              emit_res  = mk_res(8'h00, 1'b0, 1'b0, i2p_pkg::ST_UNKNOWN);
              state_nxt = S_END;
            end
          endcase
        end
      end
      S_FETCH: begin
        top_nxt   = rd_data_r;
        state_nxt = ret_r;
      end
      S_END: begin
        if (go) begin
          if (cur_r.last) begin
            state_nxt = S_FLUSH;
          end else begin
            finish    = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (go) begin
          if (!stk_empty && top_r != i2p_pkg::CODE_OPEN) begin
            do_pop  = 1'b1;
            ret_nxt = S_FLUSH;
          end else begin
            cnt_nxt   = '0;
            emit      = 1'b1;
            emit_res  = mk_res(8'h00, 1'b0, 1'b1, i2p_pkg::ST_OK);
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (go) begin
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (do_push) begin
      if (stk_full) begin
        emit     = 1'b1;
        emit_res = mk_res(8'h00, 1'b0, 1'b0, i2p_pkg::ST_OVERFLOW);
      end else begin
        mem_we  = 1'b1;
        top_nxt = push_code;
        cnt_nxt = cnt_r + i2p_pkg::CNT_W'(1);
      end
    end

    if (do_pop) begin
      emit      = 1'b1;
      emit_res  = mk_res(i2p_pkg::code_char(top_r), 1'b1, 1'b0, i2p_pkg::ST_OK);
      cnt_nxt   = cnt_r - i2p_pkg::CNT_W'(1);
      state_nxt = S_FETCH;
    end

    // held result goes out when the next one arrives or the item ends
    if (emit) begin
      if (hold_v_r) begin
        oq_wr.push = 1'b1;
        oq_wr.data = hold_r;
      end
      hold_nxt   = emit_res;
      hold_v_nxt = 1'b1;
    end
    if (finish && hold_v_r) begin
      oq_wr.push          = 1'b1;
      oq_wr.data          = hold_r;
      oq_wr.data.run_last = 1'b1;
      hold_v_nxt          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
    end
    cur_r  <= cur_nxt;
    top_r  <= top_nxt;
    hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[cnt_r[i2p_pkg::PTR_W-1:0]] <= push_code;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

endmodule

[hw/rtl/i2p_outq.sv]
// Result queue between the sequencer and the output ports.
module i2p_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  i2p_pkg::oq_wr_t  oq_wr,
  output logic             oq_full,
  output logic             empty,
  input  logic             pop,
  output i2p_pkg::res_t    head
);

  i2p_pkg::res_t                 q_r [i2p_pkg::OQ_DEPTH];
  logic [i2p_pkg::OQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [i2p_pkg::OQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [i2p_pkg::OQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                          wr_en, rd_en;

  assign oq_full = (cnt_r == i2p_pkg::OQ_CNT_W'(i2p_pkg::OQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = q_r[rd_ptr_r];
  assign wr_en   = oq_wr.push && !oq_full;
  assign rd_en   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == i2p_pkg::OQ_PTR_W'(i2p_pkg::OQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + i2p_pkg::OQ_PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == i2p_pkg::OQ_PTR_W'(i2p_pkg::OQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + i2p_pkg::OQ_PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + i2p_pkg::OQ_CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - i2p_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= oq_wr.data;
    end
  end

endmodule

[hw/rtl/infix_to_postfix_converter.sv]
// Infix-to-postfix converter top level: front queue, sequencer, result queue.
// Each word runs through IDLE, EVAL and END in the sequencer, one word at a time; a popped
// operator adds an emit and a refetch of the new top, a ')' that drops its '(' a refetch,
// and the end of an expression a flush and an end marker; a full result queue stalls it.
// Reset: synchronous rst_n empties both queues, the stack count and the sequencer;
// the stack memory itself is not cleared, only entries below the count are read.
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char,
  input  logic        in_expr_last,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        out_has_char,
  output logic        out_run_last,
  output logic        out_expr_end,
  output logic [1:0]  out_status
);

  // front to back: one classified word per dequeue
  logic             item_v;
  logic             deq;
  i2p_pkg::item_t   item;

  // back to result queue
  i2p_pkg::oq_wr_t  oq_wr;
  logic             oq_full;
  i2p_pkg::res_t    head;

  i2p_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .in_char      (in_char),
    .in_expr_last (in_expr_last),
    .full         (full),
    .deq          (deq),
    .item_v       (item_v),
    .item         (item)
  );

  // The sequencer keeps one result held back so it can tag the last
  // result of each input word with run_last.
  i2p_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_v  (item_v),
    .item    (item),
    .deq     (deq),
    .oq_full (oq_full),
    .oq_wr   (oq_wr)
  );

  i2p_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .oq_wr   (oq_wr),
    .oq_full (oq_full),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign out_char     = head.ch;
  assign out_has_char = head.has_char;
  assign out_run_last = head.run_last;
  assign out_expr_end = head.expr_end;
  assign out_status   = head.status;

  // sequencer never writes a result into a full queue
  a_no_oq_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    oq_wr.push |-> !oq_full)
    else $error("result queue written while full");

  // sequencer only takes a word that is there
  a_no_fq_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    deq |-> item_v)
    else $error("front queue read while empty");

  // result queue comes out of reset empty and the input queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  // an end marker always closes the run of its input word
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oq_wr.push && oq_wr.data.expr_end) |-> oq_wr.data.run_last)
    else $error("end marker without run_last");

endmodule

[tb/tb_infix_to_postfix_converter.sv]
// Self-checking testbench for the infix-to-postfix converter, scoreboard class included.
module tb_infix_to_postfix_converter;

  // Kill time, in simulation time units; the clock toggles every unit.
  localparam int LIMIT_UNITS = 2_000_000;
  localparam int RANDOM_WORDS = 285;
  localparam int QUIET_TAIL = 50;     // last random words run with no idling
  localparam int LONG_HOLD = 300;     // receiver hold-off, in cycles

  // Tracks the operator stack and keeps the postfix words still owed.
  class postfix_scoreboard;
    logic [7:0]     op_stack [i2p_pkg::STACK_DEPTH];
    int             depth;
    i2p_pkg::res_t  batch[$];
    i2p_pkg::res_t  postfix_due[$];

    function new();
      depth = 0;
    endfunction

    function logic [1:0] rank(logic [7:0] sym);
      case (sym)
        i2p_pkg::CH_ADD, i2p_pkg::CH_SUB: return 2'd1;
        i2p_pkg::CH_MUL, i2p_pkg::CH_DIV: return 2'd2;
        i2p_pkg::CH_POW:                  return 2'd3;
        default:                          return 2'd0;
      endcase
    endfunction

    function void put(logic [7:0] c, logic has, logic fin, i2p_pkg::status_t st);
      i2p_pkg::res_t r;
      r.ch       = c;
      r.has_char = has;
      r.run_last = 1'b0;
      r.expr_end = fin;
      r.status   = st;
      batch.push_back(r);
    endfunction

    function void pop_out();
      depth--;
      put(op_stack[depth], 1'b1, 1'b0, i2p_pkg::ST_OK);
    endfunction

    function void push_sym(logic [7:0] sym);
      if (depth >= i2p_pkg::STACK_DEPTH) begin
        put(8'h00, 1'b0, 1'b0, i2p_pkg::ST_OVERFLOW);
      end else begin
        op_stack[depth] = sym;
        depth++;
      end
    endfunction

    // Works out every word that one accepted input word causes.
    function void note_word(logic [7:0] c, logic fin);
      logic [1:0] p_in;
      logic [1:0] p_top;
      batch.delete();
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9")) begin
        put(c, 1'b1, 1'b0, i2p_pkg::ST_OK);
      end else if (c == i2p_pkg::CH_OPEN) begin
        push_sym(i2p_pkg::CH_OPEN);
      end else if (c == i2p_pkg::CH_CLOSE) begin
        while (depth > 0 && op_stack[depth-1] != i2p_pkg::CH_OPEN) pop_out();
        if (depth > 0) depth--;
        else put(8'h00, 1'b0, 1'b0, i2p_pkg::ST_UNMATCHED);
      end else if (c inside {i2p_pkg::CH_ADD, i2p_pkg::CH_SUB, i2p_pkg::CH_MUL,
                             i2p_pkg::CH_DIV, i2p_pkg::CH_POW}) begin
        p_in = rank(c);
        while (depth > 0) begin
          p_top = rank(op_stack[depth-1]);
          if (p_top > p_in || (p_top == p_in && c != i2p_pkg::CH_POW)) pop_out();
          else break;
        end
        push_sym(c);
      end else begin
        put(8'h00, 1'b0, 1'b0, i2p_pkg::ST_UNKNOWN);
      end
      if (fin) begin
        while (depth > 0 && op_stack[depth-1] != i2p_pkg::CH_OPEN) pop_out();
        depth = 0;
        put(8'h00, 1'b0, 1'b1, i2p_pkg::ST_OK);
      end
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[i]) postfix_due.push_back(batch[i]);
    endfunction

    function string show(i2p_pkg::res_t r);
      return $sformatf("ch=%02h has=%0b run_last=%0b end=%0b st=%0d",
                       r.ch, r.has_char, r.run_last, r.expr_end, r.status);
    endfunction

    function bit check_word(i2p_pkg::res_t got, output string msg);
      i2p_pkg::res_t want;
      msg = "";
      if (postfix_due.size() == 0) begin
        msg = $sformatf("word with nothing pending: %s", show(got));
        return 1'b0;
      end
      want = postfix_due.pop_front();
      if (got.ch !== want.ch || got.has_char !== want.has_char ||
          got.run_last !== want.run_last || got.expr_end !== want.expr_end ||
          got.status !== want.status) begin
        msg = $sformatf("got %s, want %s", show(got), show(want));
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int outstanding();
      return postfix_due.size();
    endfunction
  endclass

  // All DUT inputs start at known values.
  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       push         = 1'b0;
  logic [7:0] in_char      = 8'h00;
  logic       in_expr_last = 1'b0;
  logic       pop          = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_char;
  logic       out_has_char;
  logic       out_run_last;
  logic       out_expr_end;
  logic [1:0] out_status;

  postfix_scoreboard sb = new();

  int         mismatch_count = 0;
  int         sent_words = 0;
  bit         tx_idle_en = 1'b1;
  bit         rx_idle_en = 1'b1;
  int         hold_asks = 0;       // bumped by the stimulus side only
  logic [7:0] seq_q[$];            // characters of the sequence being built

  always #1 clk = ~clk;

  infix_to_postfix_converter u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_char      (in_char),
    .in_expr_last (in_expr_last),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_has_char (out_has_char),
    .out_run_last (out_run_last),
    .out_expr_end (out_expr_end),
    .out_status   (out_status)
  );

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Offer one word; returns in the step of the edge that took it.
  task automatic send_word(logic [7:0] c, logic fin);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push         <= 1'b1;
    in_char      <= c;
    in_expr_last <= fin;
    do @(posedge clk); while (full);
    sb.note_word(c, fin);
    sent_words++;
  endtask

  task automatic send_queued(logic last_flag);
    foreach (seq_q[i]) send_word(seq_q[i], (i == seq_q.size() - 1) ? last_flag : 1'b0);
  endtask

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 2))
      0:       return 8'("a" + $urandom_range(0, 25));
      1:       return 8'("A" + $urandom_range(0, 25));
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 4))
      0:       return i2p_pkg::CH_ADD;
      1:       return i2p_pkg::CH_SUB;
      2:       return i2p_pkg::CH_MUL;
      3:       return i2p_pkg::CH_DIV;
      default: return i2p_pkg::CH_POW;
    endcase
  endfunction

  // Well-formed infix: terms joined by operators, nested parens up to lvl deep.
  function automatic void add_expr(int lvl);
    int n_terms;
    n_terms = $urandom_range(1, 4);
    for (int i = 0; i < n_terms; i++) begin
      if (i > 0) seq_q.push_back(pick_op());
      if (lvl > 0 && $urandom_range(0, 3) == 0) begin
        seq_q.push_back(i2p_pkg::CH_OPEN);
        add_expr(lvl - 1);
        seq_q.push_back(i2p_pkg::CH_CLOSE);
      end else begin
        seq_q.push_back(pick_alnum());
      end
    end
  endfunction

  // Damage a well-formed expression: stray parens, spaces, random bytes, drops.
  function automatic void break_expr();
    int pos;
    repeat ($urandom_range(1, 3)) begin
      pos = $urandom_range(0, seq_q.size() - 1);
      case ($urandom_range(0, 4))
        0:       seq_q[pos] = i2p_pkg::CH_CLOSE;
        1:       seq_q[pos] = i2p_pkg::CH_OPEN;
        2:       seq_q[pos] = 8'h20;
        3:       seq_q[pos] = 8'($urandom_range(0, 255));
        default: if (seq_q.size() > 1) seq_q.delete(pos);
      endcase
    end
  endfunction

  // Pile '(' and right-associative '^' so the stack comes near or past its limit.
  function automatic void deep_expr();
    repeat ($urandom_range(i2p_pkg::STACK_DEPTH - 4, i2p_pkg::STACK_DEPTH + 4)) begin
      if ($urandom_range(0, 1) == 0) begin
        seq_q.push_back(i2p_pkg::CH_OPEN);
      end else begin
        seq_q.push_back(pick_alnum());
        seq_q.push_back(i2p_pkg::CH_POW);
      end
    end
    seq_q.push_back(pick_alnum());
    repeat ($urandom_range(0, 3)) seq_q.push_back(i2p_pkg::CH_CLOSE);
  endfunction

  // Receiver: checks each popped word, idles in bursts, and honors hold-off asks.
  initial begin
    int            hold_seen;
    int            rx_hold;
    int            rx_gap;
    i2p_pkg::res_t got;
    string         msg;
    hold_seen = 0;
    rx_hold   = 0;
    rx_gap    = 0;
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        got.ch       = out_char;
        got.has_char = out_has_char;
        got.run_last = out_run_last;
        got.expr_end = out_expr_end;
        got.status   = out_status;
        if (!sb.check_word(got, msg)) report_mismatch(msg);
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        rx_hold   = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(0, 6);   // start an idle burst
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stimulus: reset, directed expressions, then random sequences.
  initial begin
    int  rand_start;
    int  kind;
    bit  drained;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every operator but '/', left vs right associativity, precedence climb
    seq_q = '{"a", i2p_pkg::CH_ADD, "b", i2p_pkg::CH_MUL, "c", i2p_pkg::CH_SUB, "d",
              i2p_pkg::CH_POW, "e", i2p_pkg::CH_POW, "f"};
    send_queued(1'b1);
    // divide, matched parens, unmatched ')' popping '/', unknown bytes at both extremes
    seq_q = '{"0", i2p_pkg::CH_DIV, i2p_pkg::CH_OPEN, "A", i2p_pkg::CH_MUL, "9",
              i2p_pkg::CH_CLOSE, i2p_pkg::CH_CLOSE, 8'hFF, 8'h00};
    send_queued(1'b1);
    // '(' left open at the end: flush stops at it and the clear drops it
    seq_q = '{i2p_pkg::CH_OPEN, "Z", i2p_pkg::CH_SUB, "z"};
    send_queued(1'b1);

    // long receiver hold-off while the sender keeps offering words
    hold_asks++;
    rand_start = sent_words;
    while (sent_words - rand_start < RANDOM_WORDS) begin
      if (sent_words - rand_start >= RANDOM_WORDS - QUIET_TAIL) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      // halfway, let the block run dry before going on
      if (!drained && sent_words - rand_start >= RANDOM_WORDS / 2) begin
        drained = 1'b1;
        push <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
      end
      seq_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        add_expr(3);
        send_queued($urandom_range(0, 9) != 0);
      end else if (kind < 78) begin
        add_expr(2);
        break_expr();
        send_queued(1'b1);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 5)) seq_q.push_back(8'($urandom_range(0, 255)));
        send_queued(1'($urandom_range(0, 1)));
      end else begin
        deep_expr();
        send_queued(1'b1);
      end
    end

    // make sure the final expression is closed out
    send_word(pick_alnum(), 1'b1);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #LIMIT_UNITS;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[infix_to_postfix_converter.f]
hw/rtl/i2p_pkg.sv
hw/rtl/i2p_front.sv
hw/rtl/i2p_back.sv
hw/rtl/i2p_outq.sv
hw/rtl/infix_to_postfix_converter.sv
tb/tb_infix_to_postfix_converter.sv
